/* rtl/core/pcm_pkg.sv */
// Shared constants and types for the position clump merger.
package pcm_pkg;

	localparam int MAX_CLUMPS_DEF    = 256;
	localparam int POSITION_BITS_DEF = 28;

	localparam int SEQ_W    = 8;
	localparam int WINDOW_W = 16;
	localparam int HSCORE_W = 16;
	localparam int SUM_W    = 32;
	localparam int OUTIDX_W = 8;

	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd25;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} pcm_state_t;

endpackage

/* rtl/core/pcm_cell.sv */
// One table slot: holds a clump and passes the newest-match record down the chain.
module pcm_cell #(
	parameter int SLOT          = 0,
	parameter int MAX_CLUMPS    = pcm_pkg::MAX_CLUMPS_DEF,
	parameter int POSITION_BITS = pcm_pkg::POSITION_BITS_DEF,
	parameter int IDX_W         = $clog2(MAX_CLUMPS),
	parameter int CNT_W         = $clog2(MAX_CLUMPS + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Hit under search, held stable by the top level.
	input  logic [pcm_pkg::SEQ_W-1:0]    hit_seq,
	input  logic [POSITION_BITS-1:0]     win_lo,
	input  logic [POSITION_BITS:0]       win_hi,
	input  logic [CNT_W-1:0]             used,
	// Broadcast write port.
	input  logic                         wr_en,
	input  logic [IDX_W-1:0]             wr_idx,
	input  logic [pcm_pkg::SEQ_W-1:0]    wr_seq,
	input  logic [POSITION_BITS-1:0]     wr_start,
	input  logic [POSITION_BITS-1:0]     wr_end,
	input  logic [pcm_pkg::SUM_W-1:0]    wr_score,
	// Record from the next higher slot.
	input  logic                         in_found,
	input  logic [IDX_W-1:0]             in_idx,
	input  logic [POSITION_BITS-1:0]     in_start,
	input  logic [POSITION_BITS-1:0]     in_end,
	input  logic [pcm_pkg::SUM_W-1:0]    in_score,
	// Record toward the next lower slot.
	output logic                         out_found,
	output logic [IDX_W-1:0]             out_idx,
	output logic [POSITION_BITS-1:0]     out_start,
	output logic [POSITION_BITS-1:0]     out_end,
	output logic [pcm_pkg::SUM_W-1:0]    out_score
);
	import pcm_pkg::*;

	logic [SEQ_W-1:0]         seq_q;
	logic [POSITION_BITS-1:0] start_q;
	logic [POSITION_BITS-1:0] end_q;
	logic [SUM_W-1:0]         score_q;

	logic                     found_q;
	logic [IDX_W-1:0]         idx_q;
	logic [POSITION_BITS-1:0] rec_start_q;
	logic [POSITION_BITS-1:0] rec_end_q;
	logic [SUM_W-1:0]         rec_score_q;

	logic occupied;
	logic match;

	assign occupied = used > CNT_W'(SLOT);
	assign match = occupied && (seq_q == hit_seq) &&
		(win_hi >= {1'b0, start_q}) && (win_lo <= end_q);

	always_ff @(posedge clk) begin
		if (wr_en && (wr_idx == IDX_W'(SLOT))) begin
			seq_q   <= wr_seq;
			start_q <= wr_start;
			end_q   <= wr_end;
			score_q <= wr_score;
		end
	end

	// A record found higher up is newer and always wins over this slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else begin
			found_q <= in_found || match;
		end
	end

	always_ff @(posedge clk) begin
		if (in_found) begin
			idx_q       <= in_idx;
			rec_start_q <= in_start;
			rec_end_q   <= in_end;
			rec_score_q <= in_score;
		end else begin
			idx_q       <= IDX_W'(SLOT);
			rec_start_q <= start_q;
			rec_end_q   <= end_q;
			rec_score_q <= score_q;
		end
	end

	assign out_found = found_q;
	assign out_idx   = idx_q;
	assign out_start = rec_start_q;
	assign out_end   = rec_end_q;
	assign out_score = rec_score_q;

endmodule

/* rtl/core/position_clump_merger_top.sv */
// Position clump merger: a chain of clump slots searched newest first.
//
//   channel   handshake            payload
//   --------  -------------------  ---------------------------------------------
//   hit in    start, busy          sequence_id, position, hit_score
//   result    done (one cycle)     clump_index, opened_new, table_full,
//                                  span_start, span_end, score_sum
//   config    cfg_we               cfg_data (merge window)
//
// Each accepted hit is registered, then the match record ripples one slot per
// cycle down the chain of MAX_CLUMPS cells, and the commit state updates the
// chosen slot and registers the result. A new hit is accepted in the cycle
// the result strobe is shown. Reset clears the slot count and sets the window
// to 25; slot contents are only read once written. The receiver cannot stall.
module position_clump_merger_top #(
	parameter int MAX_CLUMPS    = pcm_pkg::MAX_CLUMPS_DEF,
	parameter int POSITION_BITS = pcm_pkg::POSITION_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [pcm_pkg::SEQ_W-1:0]      sequence_id,
	input  logic [POSITION_BITS-1:0]       position,
	input  logic [pcm_pkg::HSCORE_W-1:0]   hit_score,
	input  logic                           cfg_we,
	input  logic [pcm_pkg::WINDOW_W-1:0]   cfg_data,
	output logic                           done,
	output logic [pcm_pkg::OUTIDX_W-1:0]   clump_index,
	output logic                           opened_new,
	output logic                           table_full,
	output logic [POSITION_BITS-1:0]       span_start,
	output logic [POSITION_BITS-1:0]       span_end,
	output logic [pcm_pkg::SUM_W-1:0]      score_sum
);
	import pcm_pkg::*;

	localparam int IDX_W = $clog2(MAX_CLUMPS);
	localparam int CNT_W = $clog2(MAX_CLUMPS + 1);

	pcm_state_t state_q, state_d;

	logic [WINDOW_W-1:0]      window_q;
	logic [CNT_W-1:0]         used_q;
	logic [CNT_W-1:0]         scan_cnt_q;

	logic [SEQ_W-1:0]         seq_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [HSCORE_W-1:0]      hscore_q;
	logic [POSITION_BITS-1:0] win_lo_q;
	logic [POSITION_BITS:0]   win_hi_q;

	logic                     done_q;
	logic [OUTIDX_W-1:0]      clump_index_q;
	logic                     opened_new_q;
	logic                     table_full_q;
	logic [POSITION_BITS-1:0] span_start_q;
	logic [POSITION_BITS-1:0] span_end_q;
	logic [SUM_W-1:0]         score_sum_q;

	logic                     link_found [0:MAX_CLUMPS];
	logic [IDX_W-1:0]         link_idx   [0:MAX_CLUMPS];
	logic [POSITION_BITS-1:0] link_start [0:MAX_CLUMPS];
	logic [POSITION_BITS-1:0] link_end   [0:MAX_CLUMPS];
	logic [SUM_W-1:0]         link_score [0:MAX_CLUMPS];

	logic                     accept;
	logic                     full;
	logic                     scan_last;
	logic                     wr_en;
	logic [IDX_W-1:0]         wr_idx;
	logic [POSITION_BITS-1:0] wr_start;
	logic [POSITION_BITS-1:0] wr_end;
	logic [SUM_W-1:0]         wr_score;
	logic [SUM_W:0]           sum_wide;
	logic [POSITION_BITS-1:0] window_ext;

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign full       = (used_q == CNT_W'(MAX_CLUMPS));
	assign scan_last  = (scan_cnt_q == CNT_W'(MAX_CLUMPS - 1));
	assign window_ext = POSITION_BITS'(window_q);

	// The top of the chain never carries a match.
	assign link_found[MAX_CLUMPS] = 1'b0;
	assign link_idx[MAX_CLUMPS]   = '0;
	assign link_start[MAX_CLUMPS] = '0;
	assign link_end[MAX_CLUMPS]   = '0;
	assign link_score[MAX_CLUMPS] = '0;

	for (genvar g = 0; g < MAX_CLUMPS; g++) begin : g_cell
		pcm_cell #(
			.SLOT          (g),
			.MAX_CLUMPS    (MAX_CLUMPS),
			.POSITION_BITS (POSITION_BITS),
			.IDX_W         (IDX_W),
			.CNT_W         (CNT_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.hit_seq   (seq_q),
			.win_lo    (win_lo_q),
			.win_hi    (win_hi_q),
			.used      (used_q),
			.wr_en     (wr_en),
			.wr_idx    (wr_idx),
			.wr_seq    (seq_q),
			.wr_start  (wr_start),
			.wr_end    (wr_end),
			.wr_score  (wr_score),
			.in_found  (link_found[g+1]),
			.in_idx    (link_idx[g+1]),
			.in_start  (link_start[g+1]),
			.in_end    (link_end[g+1]),
			.in_score  (link_score[g+1]),
			.out_found (link_found[g]),
			.out_idx   (link_idx[g]),
			.out_start (link_start[g]),
			.out_end   (link_end[g]),
			.out_score (link_score[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg_we) begin
			window_q <= cfg_data;
		end
	end

	// Hit registers; the upper window bound is widened and the lower one clamped at zero so they never wrap.
	always_ff @(posedge clk) begin
		if (accept) begin
			seq_q    <= sequence_id;
			pos_q    <= position;
			hscore_q <= hit_score;
			win_hi_q <= {1'b0, position} + {1'b0, window_ext};
			win_lo_q <= (position >= window_ext) ? (position - window_ext) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Slot update computed from the record that reached the bottom of the chain.
	always_comb begin
		sum_wide = {1'b0, link_score[0]} + (SUM_W + 1)'(hscore_q);
		if (link_found[0]) begin
			wr_idx = link_idx[0];
			if (pos_q < link_start[0]) begin
				wr_start = pos_q;
				wr_end   = link_end[0];
			end else if (pos_q > link_end[0]) begin
				wr_start = link_start[0];
				wr_end   = pos_q;
			end else begin
				wr_start = link_start[0];
				wr_end   = link_end[0];
			end
			wr_score = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
		end else begin
			wr_idx   = IDX_W'(used_q);
			wr_start = pos_q;
			wr_end   = pos_q;
			wr_score = SUM_W'(hscore_q);
		end
		wr_en = (state_q == ST_COMMIT) && (link_found[0] || !full);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			scan_cnt_q <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= (state_q == ST_COMMIT);
			if (accept) begin
				scan_cnt_q <= '0;
			end else if (state_q == ST_SCAN) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
			if ((state_q == ST_COMMIT) && !link_found[0] && !full) begin
				used_q <= used_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_COMMIT) begin
			if (!link_found[0] && full) begin
				clump_index_q <= '0;
				opened_new_q  <= 1'b0;
				table_full_q  <= 1'b1;
				span_start_q  <= '0;
				span_end_q    <= '0;
				score_sum_q   <= '0;
			end else begin
				clump_index_q <= OUTIDX_W'(wr_idx);
				opened_new_q  <= !link_found[0];
				table_full_q  <= 1'b0;
				span_start_q  <= wr_start;
				span_end_q    <= wr_end;
				score_sum_q   <= wr_score;
			end
		end
	end

	assign done        = done_q;
	assign clump_index = clump_index_q;
	assign opened_new  = opened_new_q;
	assign table_full  = table_full_q;
	assign span_start  = span_start_q;
	assign span_end    = span_end_q;
	assign score_sum   = score_sum_q;

endmodule

/* rtl/core/pcm_chk.sv */
// Port-level checks for the position clump merger, bound to the top level.
module pcm_chk #(
	parameter int POSITION_BITS = pcm_pkg::POSITION_BITS_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic [pcm_pkg::OUTIDX_W-1:0] clump_index,
	input logic                         opened_new,
	input logic                         table_full,
	input logic [POSITION_BITS-1:0]     span_start,
	input logic [POSITION_BITS-1:0]     span_end,
	input logic [pcm_pkg::SUM_W-1:0]    score_sum
);
	import pcm_pkg::*;

	// An accepted transaction keeps the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	// A result only follows a busy cycle and is shown while idle.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result strobe without preceding work");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(opened_new && table_full))
		else $error("opened_new and table_full both set");

	// A dropped hit reports an empty clump.
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && table_full |-> (clump_index == '0) && (span_start == '0) &&
			(span_end == '0) && (score_sum == '0))
		else $error("dropped hit reported nonzero clump data");

	// A clump's span is never inverted.
	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		done && !table_full |-> span_start <= span_end)
		else $error("clump start beyond clump end");

endmodule

bind position_clump_merger_top pcm_chk #(
	.POSITION_BITS (POSITION_BITS)
) u_pcm_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.clump_index (clump_index),
	.opened_new  (opened_new),
	.table_full  (table_full),
	.span_start  (span_start),
	.span_end    (span_end),
	.score_sum   (score_sum)
);
